// ===== rtl/multi_mode_text_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// multi_mode_text_decoder_defines.svh
// Assertion macros shared by the decoder's modules.
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_TEXT_DECODER_DEFINES_SVH
`define MULTI_MODE_TEXT_DECODER_DEFINES_SVH

// The antecedent implies the consequent in the same cycle, outside reset.
`define MMTD_ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// The condition never holds at a clock edge, outside reset.
`define MMTD_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/mmtd_pkg.sv =====
// ----------------------------------------------------------------------------
// mmtd_pkg
// Types, constants and character functions of the multi-mode text decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mmtd_pkg;

	// Decode modes held in the configuration register.
	typedef enum logic [1:0] {
		MODE_PASS  = 2'd0,
		MODE_B64   = 2'd1,
		MODE_ROT13 = 2'd2,
		MODE_HEX   = 2'd3
	} mmtd_mode_t;

	localparam logic [7:0] ROT_SHIFT = 8'd13;
	localparam logic [7:0] PAD_CHAR  = 8'h3D;
	localparam int unsigned ACC_W    = 18;

	// One queued bundle: up to three result bytes produced by one input word.
	typedef struct packed {
		logic [7:0] octet0;
		logic [7:0] octet1;
		logic [7:0] octet2;
		logic [1:0] n;      // number of results, 1 to 3
		logic       data;   // bytes carry data; clear for the empty end marker
		logic       bad;    // an invalid symbol was seen for these results
		logic       last;   // final bundle of the string
	} mmtd_entry_t;

	// Queue status seen by the front and back ends.
	typedef struct packed {
		logic full;
		logic empty;
	} mmtd_qstat_t;

	typedef struct packed {
		logic [5:0] val;
		logic       pad;
		logic       bad;
	} mmtd_b64_t;

	typedef struct packed {
		logic [3:0] val;
		logic       bad;
	} mmtd_hex_t;

	// Standard base64 alphabet lookup.
	function automatic mmtd_b64_t b64_decode(input logic [7:0] c);
		mmtd_b64_t  r;
		logic [7:0] t;
		r = '0;
		t = '0;
		if (c inside {[8'h41:8'h5A]}) begin
			t = c - 8'h41;
		end else if (c inside {[8'h61:8'h7A]}) begin
			t = c - 8'h61 + 8'd26;
		end else if (c inside {[8'h30:8'h39]}) begin
			t = c - 8'h30 + 8'd52;
		end else if (c == 8'h2B) begin
			t = 8'd62;
		end else if (c == 8'h2F) begin
			t = 8'd63;
		end else if (c == PAD_CHAR) begin
			r.pad = 1'b1;
		end else begin
			r.bad = 1'b1;
		end
		r.val = t[5:0];
		return r;
	endfunction

	// Hex digit lookup; an invalid digit reads as zero.
	function automatic mmtd_hex_t hex_decode(input logic [7:0] c);
		mmtd_hex_t  r;
		logic [7:0] t;
		r = '0;
		t = '0;
		if (c inside {[8'h30:8'h39]}) begin
			t = c - 8'h30;
		end else if (c inside {[8'h61:8'h66]}) begin
			t = c - 8'h61 + 8'd10;
		end else if (c inside {[8'h41:8'h46]}) begin
			t = c - 8'h41 + 8'd10;
		end else begin
			r.bad = 1'b1;
		end
		r.val = t[3:0];
		return r;
	endfunction

	// ROT13 on letters; everything else passes unchanged.
	function automatic logic [7:0] rot13(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[8'h61:8'h6D], [8'h41:8'h4D]}) begin
			r = c + ROT_SHIFT;
		end else if (c inside {[8'h6E:8'h7A], [8'h4E:8'h5A]}) begin
			r = c - ROT_SHIFT;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mmtd_front.sv =====
// ----------------------------------------------------------------------------
// mmtd_front
// Accepts input words, keeps the stream state and builds result bundles.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_mode_text_decoder_defines.svh"

module mmtd_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_we,
	input  wire  [1:0]             cfg_mode,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire  [7:0]             in_char,
	input  wire                    last_char,
	input  mmtd_pkg::mmtd_qstat_t  qstat,
	output logic                   push,
	output mmtd_pkg::mmtd_entry_t  push_entry
);
	import mmtd_pkg::*;

	mmtd_mode_t        mode_q;
	logic [ACC_W-1:0]  accum_q, accum_n;
	logic [1:0]        cnt_q, cnt_n;
	logic [1:0]        pad_q, pad_n;
	logic [3:0]        nib_q, nib_n;
	logic              held_q, held_n;
	logic              err_q, err_n;
	logic              accept;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;

	// Decode one word against the current stream state.
	always_comb begin
		mmtd_b64_t   b;
		mmtd_hex_t   h;
		logic [5:0]  sym;
		logic [1:0]  pad_inc;
		logic [23:0] triple;
		logic [2:0]  pads;
		logic [1:0]  nres;
		mmtd_entry_t ent;

		accum_n = accum_q;
		cnt_n   = cnt_q;
		pad_n   = pad_q;
		nib_n   = nib_q;
		held_n  = held_q;
		err_n   = err_q;
		b       = b64_decode(in_char);
		h       = hex_decode(in_char);
		sym     = b.val;
		pad_inc = pad_q;
		triple  = '0;
		pads    = 3'd3;
		nres    = 2'd0;
		ent     = '0;

		case (mode_q)
			MODE_PASS: begin
				ent.octet0 = in_char;
				nres       = 2'd1;
			end
			MODE_ROT13: begin
				ent.octet0 = rot13(in_char);
				nres       = 2'd1;
			end
			MODE_B64: begin
				if (b.bad) begin
					err_n = 1'b1;
				end else begin
					if (b.pad && pad_q != 2'd3) begin
						pad_inc = pad_q + 2'd1;
					end
					if (cnt_q == 2'd3) begin
						// Fourth symbol closes the group.
						triple  = {accum_q, sym};
						pads    = {1'b0, pad_inc};
						accum_n = '0;
						cnt_n   = 2'd0;
						pad_n   = 2'd0;
					end else begin
						accum_n = {accum_q[ACC_W-7:0], sym};
						cnt_n   = cnt_q + 2'd1;
						pad_n   = pad_inc;
					end
				end
				// A partial group at the end is padded out.
				if (last_char) begin
					case (cnt_n)
						2'd1: begin
							triple = {accum_n[5:0], 18'd0};
							pads   = {1'b0, pad_n} + 3'd3;
						end
						2'd2: begin
							triple = {accum_n[11:0], 12'd0};
							pads   = {1'b0, pad_n} + 3'd2;
						end
						2'd3: begin
							triple = {accum_n[17:0], 6'd0};
							pads   = {1'b0, pad_n} + 3'd1;
						end
						default: begin
						end
					endcase
				end
				nres       = (pads >= 3'd3) ? 2'd0 : 2'(3'd3 - pads);
				ent.octet0 = triple[23:16];
				ent.octet1 = triple[15:8];
				ent.octet2 = triple[7:0];
			end
			MODE_HEX: begin
				if (h.bad) begin
					err_n = 1'b1;
				end
				if (held_q) begin
					ent.octet0 = {nib_q, h.val};
					nres       = 2'd1;
					held_n     = 1'b0;
					nib_n      = 4'd0;
				end else if (last_char) begin
					ent.octet0 = {4'd0, h.val};
					nres       = 2'd1;
				end else begin
					nib_n  = h.val;
					held_n = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Error flag rides on every result of this word.
		ent.bad  = err_n;
		ent.data = 1'b1;
		ent.last = last_char;
		ent.n    = nres;
		if (nres != 2'd0) begin
			err_n = 1'b0;
		end
		if (last_char) begin
			// The empty end marker carries a zero byte.
			if (nres == 2'd0) begin
				ent.n      = 2'd1;
				ent.data   = 1'b0;
				ent.octet0 = '0;
			end
			accum_n = '0;
			cnt_n   = 2'd0;
			pad_n   = 2'd0;
			nib_n   = 4'd0;
			held_n  = 1'b0;
			err_n   = 1'b0;
		end

		push       = accept && (nres != 2'd0 || last_char);
		push_entry = ent;
	end

	// Mode register and stream state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PASS;
			accum_q <= '0;
			cnt_q   <= '0;
			pad_q   <= '0;
			nib_q   <= '0;
			held_q  <= 1'b0;
			err_q   <= 1'b0;
		end else if (cfg_we) begin
			mode_q  <= mmtd_mode_t'(cfg_mode);
			accum_q <= '0;
			cnt_q   <= '0;
			pad_q   <= '0;
			nib_q   <= '0;
			held_q  <= 1'b0;
			err_q   <= 1'b0;
		end else if (accept) begin
			accum_q <= accum_n;
			cnt_q   <= cnt_n;
			pad_q   <= pad_n;
			nib_q   <= nib_n;
			held_q  <= held_n;
			err_q   <= err_n;
		end
	end

	`MMTD_ASSERT_IMPLIES(a_last_pushes, clk, arst_n, accept && last_char, push, "last word queued nothing")
	`MMTD_ASSERT_IMPLIES(a_push_count, clk, arst_n, push, push_entry.n != 2'd0, "empty bundle pushed")
	`MMTD_ASSERT_NEVER(a_held_b64, clk, arst_n, held_q && mode_q != MODE_HEX, "nibble held outside hex mode")

endmodule

`default_nettype wire

// ===== rtl/mmtd_queue.sv =====
// ----------------------------------------------------------------------------
// mmtd_queue
// Short bundle queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_mode_text_decoder_defines.svh"

module mmtd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  mmtd_pkg::mmtd_entry_t  push_entry,
	input  wire                    pop,
	output mmtd_pkg::mmtd_entry_t  head,
	output mmtd_pkg::mmtd_qstat_t  qstat
);
	import mmtd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

	mmtd_entry_t       slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign head        = slot_q[rd_ptr_q];
	assign qstat.full  = (cnt_q == CNT_W'(DEPTH));
	assign qstat.empty = (cnt_q == '0);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`MMTD_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && qstat.empty, "pop from empty queue")
	`MMTD_ASSERT_NEVER(a_push_full, clk, arst_n, push && qstat.full, "push into full queue")
	`MMTD_ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > CNT_W'(DEPTH), "fill count past depth")

endmodule

`default_nettype wire

// ===== rtl/mmtd_back.sv =====
// ----------------------------------------------------------------------------
// mmtd_back
// Unpacks queued bundles into single results behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_mode_text_decoder_defines.svh"

module mmtd_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  mmtd_pkg::mmtd_entry_t  head,
	input  mmtd_pkg::mmtd_qstat_t  qstat,
	output logic                   pop,
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic [7:0]             out_byte,
	output logic                   byte_valid,
	output logic                   bad_char,
	output logic                   out_last
);
	import mmtd_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       data_q, bad_q, last_q;
	logic       load, at_end;
	logic [7:0] sel_byte;

	assign load   = !qstat.empty && (!valid_q || !out_stall);
	assign at_end = (idx_q + 2'd1 == head.n);
	assign pop    = load && at_end;

	// Pick the byte of the head bundle that goes out next.
	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.octet0;
			2'd1:    sel_byte = head.octet1;
			2'd2:    sel_byte = head.octet2;
			default: sel_byte = '0;
		endcase
	end

	// Output register and position within the head bundle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= sel_byte;
			data_q <= head.data;
			bad_q  <= head.bad;
			last_q <= head.last && at_end;
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign byte_valid = data_q;
	assign bad_char   = bad_q;
	assign out_last   = last_q;

	`MMTD_ASSERT_IMPLIES(a_mid_bundle, clk, arst_n, idx_q != 2'd0, !qstat.empty, "bundle lost mid-way")
	`MMTD_ASSERT_IMPLIES(a_idx_range, clk, arst_n, !qstat.empty, idx_q < head.n, "index past bundle")
	`MMTD_ASSERT_IMPLIES(a_marker_byte, clk, arst_n, valid_q && !data_q, byte_q == 8'd0, "end marker byte not zero")

endmodule

`default_nettype wire

// ===== rtl/multi_mode_text_decoder.sv =====
// ----------------------------------------------------------------------------
// multi_mode_text_decoder
// Character stream decoder: pass-through, base64, ROT13 or hex pairs.
// ----------------------------------------------------------------------------
// One character word is accepted per cycle while the bundle queue has room
// (in_stall is the queue's full flag). The front end decodes each word in the
// cycle it is accepted and queues the up to three bytes it produces; the back
// end sends results out one per cycle, while out_stall is low, through an
// output register. A word's results pass through a queue slot and then the
// output register. The queue holds QUEUE_DEPTH bundles. decode_mode must be
// written only while the block is idle (the block does not enforce this); a
// write clears all stream state. cfg_ready is always high.
`default_nettype none

module multi_mode_text_decoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire  [1:0] decode_mode,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] in_char,
	input  wire        last_char,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       bad_char,
	output logic       out_last
);
	import mmtd_pkg::*;

	mmtd_qstat_t qstat;
	mmtd_entry_t push_entry, head;
	logic        push, pop, cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Front end: stream state and word decode.
	mmtd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_mode   (decode_mode),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_char    (in_char),
		.last_char  (last_char),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	// Bundle queue.
	mmtd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// Back end: one result per cycle while out_stall is low.
	mmtd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.bad_char   (bad_char),
		.out_last   (out_last)
	);

endmodule

`default_nettype wire
